@@ rtl/saxman_lzss_decompressor_unit_defines.svh @@
// assertion macros shared by the decompressor
`ifndef SAXMAN_LZSS_DECOMPRESSOR_UNIT_DEFINES_SVH
`define SAXMAN_LZSS_DECOMPRESSOR_UNIT_DEFINES_SVH

// cond must hold at every clock edge outside reset
`define SAXLZ_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) \
        else $error(msg);

// ante implies cons in the same cycle, outside reset
`define SAXLZ_ASSERT_IMPLIES(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

@@ rtl/saxlz_pkg.sv @@
package saxlz_pkg;

    localparam int unsigned WIN_AW = 12;
    localparam int unsigned CNT_W  = 16;
    localparam logic [WIN_AW-1:0] ADDR_BIAS = 12'h012;
    // length of a match minus one is the low nibble plus this
    localparam logic [4:0] LEN_M1_BIAS = 5'd2;
    localparam logic [3:0] FLAGS_PER_DESC = 4'd8;
    localparam logic [WIN_AW:0] WIN_FULL = 13'h1000;
    localparam logic [CNT_W-1:0] CNT_MAX = 16'hFFFF;

    typedef enum logic [1:0] {
        PH_START    = 2'd0,
        PH_LITERAL  = 2'd1,
        PH_MATCH_LO = 2'd2,
        PH_MATCH_HI = 2'd3
    } t_phase;

    typedef enum logic [1:0] {
        BK_IDLE  = 2'd0,
        BK_READ  = 2'd1,
        BK_WRITE = 2'd2
    } t_bstate;

    typedef struct packed {
        logic       is_lit;
        logic [7:0] b0;
        logic [7:0] b1;
    } t_cmd;

    typedef struct packed {
        logic empty;
        logic full;
    } t_q_stat;

endpackage

@@ rtl/saxlz_front.sv @@
module saxlz_front
    import saxlz_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_accept,
    input  logic [7:0]       i_in_byte,
    input  logic [CNT_W-1:0] i_stream_length,
    output logic             o_push,
    output t_cmd             o_cmd
);

    t_phase           r_phase, n_phase;
    logic [7:0]       r_flag_byte, n_flag_byte;
    logic [3:0]       r_flags_left, n_flags_left;
    logic [7:0]       r_held, n_held;
    logic [CNT_W-1:0] r_consumed, n_consumed;

    logic live;
    logic new_desc;

    // a token only starts while the stream has bytes left
    assign live     = (r_phase != PH_START) || (r_consumed < i_stream_length);
    assign new_desc = (r_phase == PH_START) && (r_flags_left == '0);

    // next phase
    always_comb begin
        n_phase = r_phase;
        if (i_accept && live) begin
            unique case (r_phase)
                PH_START: begin
                    if (new_desc) begin
                        n_phase = i_in_byte[0] ? PH_LITERAL : PH_MATCH_LO;
                    end else if (r_flag_byte[0]) begin
                        n_phase = PH_START;
                    end else begin
                        n_phase = PH_MATCH_HI;
                    end
                end
                PH_LITERAL:  n_phase = PH_START;
                PH_MATCH_LO: n_phase = PH_MATCH_HI;
                PH_MATCH_HI: n_phase = PH_START;
                default:     n_phase = PH_START;
            endcase
        end
    end

    // outputs and parse registers
    always_comb begin
        logic finish;
        finish       = 1'b0;
        o_push       = 1'b0;
        o_cmd.is_lit = 1'b1;
        o_cmd.b0     = i_in_byte;
        o_cmd.b1     = i_in_byte;
        n_flag_byte  = r_flag_byte;
        n_flags_left = r_flags_left;
        n_held       = r_held;
        n_consumed   = r_consumed;
        if (i_accept && live) begin
            if (r_consumed != CNT_MAX) begin
                n_consumed = r_consumed + 1'b1;
            end
            unique case (r_phase)
                PH_START: begin
                    if (new_desc) begin
                        n_flag_byte  = i_in_byte;
                        n_flags_left = FLAGS_PER_DESC;
                    end else if (r_flag_byte[0]) begin
                        o_push = 1'b1;
                        finish = 1'b1;
                    end else begin
                        n_held = i_in_byte;
                    end
                end
                PH_LITERAL: begin
                    o_push = 1'b1;
                    finish = 1'b1;
                end
                PH_MATCH_LO: n_held = i_in_byte;
                PH_MATCH_HI: begin
                    o_push       = 1'b1;
                    o_cmd.is_lit = 1'b0;
                    o_cmd.b0     = r_held;
                    finish       = 1'b1;
                end
                default: ;
            endcase
            if (finish) begin
                n_flag_byte = r_flag_byte >> 1;
                if (r_flags_left != '0) begin
                    n_flags_left = r_flags_left - 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_START;
            r_flag_byte  <= '0;
            r_flags_left <= '0;
            r_consumed   <= '0;
        end else begin
            r_phase      <= n_phase;
            r_flag_byte  <= n_flag_byte;
            r_flags_left <= n_flags_left;
            r_consumed   <= n_consumed;
        end
    end

    always_ff @(posedge i_clk) begin
        r_held <= n_held;
    end

endmodule

@@ rtl/saxlz_fifo.sv @@
module saxlz_fifo
    import saxlz_pkg::*;
#(
    parameter int unsigned DEPTH = 2
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_cmd    i_cmd,
    input  logic    i_pop,
    output t_cmd    o_cmd,
    output t_q_stat o_stat
);

    localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);

    t_cmd          r_mem [DEPTH];
    logic [PW-1:0] r_wr, n_wr;
    logic [PW-1:0] r_rd, n_rd;
    logic [CW-1:0] r_cnt, n_cnt;

    assign o_stat.empty = (r_cnt == '0);
    assign o_stat.full  = (r_cnt == CW'(DEPTH));
    assign o_cmd        = r_mem[r_rd];

    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (i_push) begin
            n_wr = (r_wr == PW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
        end
        if (i_pop) begin
            n_rd = (r_rd == PW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (i_pop && !i_push) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_cmd;
        end
    end

endmodule

@@ rtl/saxlz_back.sv @@
module saxlz_back
    import saxlz_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cmd_valid,
    input  t_cmd       i_cmd,
    output logic       o_pop,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [7:0] o_out_byte,
    output logic       o_last_of_run
);

    localparam int unsigned DEPTH = 1 << WIN_AW;

    logic [7:0]        r_hist [DEPTH];
    logic [7:0]        r_rdata;
    t_bstate           r_state, n_state;
    logic [WIN_AW-1:0] r_src, n_src;
    logic [WIN_AW-1:0] r_wp;
    logic [WIN_AW:0]   r_prod;
    logic [4:0]        r_left, n_left;
    logic              r_zf, n_zf;
    logic              r_lit, n_lit;
    logic [7:0]        r_litval, n_litval;
    logic              r_out_valid;
    logic [7:0]        r_out_byte;
    logic              r_out_last;

    logic              can_load;
    logic              load;
    logic              written;
    logic [7:0]        wr_val;
    logic [WIN_AW-1:0] m_addr;
    logic [WIN_AW-1:0] m_dist;

    assign can_load = !r_out_valid || i_ready;
    assign m_addr   = {i_cmd.b1[7:4], i_cmd.b0} + ADDR_BIAS;
    assign m_dist   = r_wp - m_addr;
    // an entry past the fill count was never written and reads as zero
    assign written  = r_prod[WIN_AW] || ({1'b0, r_src} < r_prod);
    assign wr_val   = r_lit ? r_litval : ((r_zf || !written) ? 8'h00 : r_rdata);

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            BK_IDLE: begin
                if (i_cmd_valid) begin
                    n_state = i_cmd.is_lit ? BK_WRITE : BK_READ;
                end
            end
            BK_READ: n_state = BK_WRITE;
            BK_WRITE: begin
                if (can_load) begin
                    n_state = (r_left == '0) ? BK_IDLE : BK_READ;
                end
            end
            default: n_state = BK_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_pop = 1'b0;
        load  = 1'b0;
        unique case (r_state)
            BK_IDLE:  o_pop = i_cmd_valid;
            BK_READ:  ;
            BK_WRITE: load = can_load;
            default:  ;
        endcase
    end

    // per-command registers
    always_comb begin
        n_src    = r_src;
        n_left   = r_left;
        n_zf     = r_zf;
        n_lit    = r_lit;
        n_litval = r_litval;
        if (o_pop) begin
            n_lit    = i_cmd.is_lit;
            n_litval = i_cmd.b1;
            n_src    = m_addr;
            n_zf     = ({1'b0, m_dist} > r_prod);
            n_left   = i_cmd.is_lit ? 5'd0 : {1'b0, i_cmd.b1[3:0]} + LEN_M1_BIAS;
        end else if (load && (r_left != '0)) begin
            n_left = r_left - 1'b1;
            n_src  = r_src + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= BK_IDLE;
            r_wp        <= '0;
            r_prod      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (load) begin
                r_wp <= r_wp + 1'b1;
                if (r_prod != WIN_FULL) begin
                    r_prod <= r_prod + 1'b1;
                end
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_src    <= n_src;
        r_left   <= n_left;
        r_zf     <= n_zf;
        r_lit    <= n_lit;
        r_litval <= n_litval;
        if (load) begin
            r_out_byte <= wr_val;
            r_out_last <= (r_left == '0);
        end
    end

    // history window
    always_ff @(posedge i_clk) begin
        if (r_state == BK_READ) begin
            r_rdata <= r_hist[r_src];
        end
        if (load) begin
            r_hist[r_wp] <= wr_val;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_out_byte    = r_out_byte;
    assign o_last_of_run = r_out_last;

endmodule

@@ rtl/saxman_lzss_decompressor_unit.sv @@
// lzss decompressor for saxman-style streams: compressed bytes go in one
// per item on the input channel, decompressed bytes come out one per item,
// with o_last_of_run marking the final byte produced by an input byte.
// descriptor bytes and the first byte of a match produce nothing; a literal
// produces one byte, a match 3 to 18. a parser takes one input byte per
// cycle while its command queue has room; the executor drains the queue and
// is the limit on rate: it pops a command, then a literal takes one write
// step, and each copied byte of a match a read then a write of the single-port
// 4096-byte history. the history reads as zeros after reset through a fill
// count, so there is no clearing pass and items are taken at once.
// program stream_length (byte address 0) while the block is idle; bytes
// arriving at a token start once that many bytes were consumed are dropped
`include "saxman_lzss_decompressor_unit_defines.svh"

module saxman_lzss_decompressor_unit
    import saxlz_pkg::*;
#(
    parameter int unsigned QUEUE_DEPTH = 2
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // compressed input
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [7:0]  i_in_byte,
    // decompressed output
    output logic        o_valid,
    input  logic        i_ready,
    output logic [7:0]  o_out_byte,
    output logic        o_last_of_run,
    // register port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [CNT_W-1:0] r_stream_length;
    logic             in_accept;
    logic             push;
    logic             pop;
    t_cmd             push_cmd;
    t_cmd             head_cmd;
    t_q_stat          q_stat;

    // register file: only stream_length, at word 0
    assign pready = 1'b1;
    assign prdata = (paddr[2] == 1'b0) ? {16'h0000, r_stream_length} : 32'h0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stream_length <= '0;
        end else if (psel && penable && pwrite && pready && (paddr[2] == 1'b0)) begin
            r_stream_length <= pwdata[CNT_W-1:0];
        end
    end

    // parser accepts whenever the queue can take a command
    assign o_ready   = !q_stat.full;
    assign in_accept = i_valid && o_ready;

    saxlz_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_accept        (in_accept),
        .i_in_byte       (i_in_byte),
        .i_stream_length (r_stream_length),
        .o_push          (push),
        .o_cmd           (push_cmd)
    );

    // literal and match commands wait here for the executor
    saxlz_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .i_pop   (pop),
        .o_cmd   (head_cmd),
        .o_stat  (q_stat)
    );

    // executor: history window, copy loop and output register
    saxlz_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd_valid   (!q_stat.empty),
        .i_cmd         (head_cmd),
        .o_pop         (pop),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_out_byte    (o_out_byte),
        .o_last_of_run (o_last_of_run)
    );

    // queue never overflows or underflows
    `SAXLZ_ASSERT_IMPLIES(a_no_push_full, push, !q_stat.full, "command pushed into full queue")
    `SAXLZ_ASSERT_IMPLIES(a_no_pop_empty, pop, !q_stat.empty, "command popped from empty queue")
    `SAXLZ_ASSERT_ALWAYS(a_q_stat_sane, !(q_stat.full && q_stat.empty), "queue full and empty")

endmodule

@@ test/tb_saxman_lzss_decompressor_unit.sv @@
module tb_saxman_lzss_decompressor_unit;
    import saxlz_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // register map
    localparam logic [2:0] REG_STREAM_LENGTH = 3'd0;
    // no register lives here, writes must leave the block unchanged
    localparam logic [2:0] REG_UNMAPPED      = 3'd4;

    // a match copies up to 18 bytes and the command queue holds two
    localparam int DRAIN_CYCLES = 96;
    localparam int HOLD_CYCLES  = 400;
    localparam int CYCLE_LIMIT  = 200_000;
    localparam int MAX_REPORTS  = 200;
    localparam int PHASE_ITEMS  = 20;
    localparam int NUM_DIR_ROWS = 25;

    logic        i_clk;
    logic        i_rst_n   = 1'b0;
    logic        i_valid   = 1'b0;
    logic        o_ready;
    logic [7:0]  i_in_byte = 8'h00;
    logic        o_valid;
    logic        i_ready   = 1'b0;
    logic [7:0]  o_out_byte;
    logic        o_last_of_run;
    logic        psel      = 1'b0;
    logic        penable   = 1'b0;
    logic        pwrite    = 1'b0;
    logic [2:0]  paddr     = 3'd0;
    logic [31:0] pwdata    = 32'h0;
    logic [31:0] prdata;
    logic        pready;

    saxman_lzss_decompressor_unit i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_in_byte     (i_in_byte),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_out_byte    (o_out_byte),
        .o_last_of_run (o_last_of_run),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    // one decompressed byte as it should leave the block
    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } t_out_item;

    // directed row: optional length write before it, optional typed-in results
    typedef struct packed {
        logic        cfg_en;
        logic [15:0] cfg_len;
        logic [7:0]  data;
        logic        typed_en;
        logic [4:0]  typed_n;
        logic [7:0]  typed_val;
    } t_dir_row;

    // first descriptor f5 gives literal, match, literal, match, then four literals;
    // the second descriptor 00 makes every following token a match
    localparam t_dir_row DIR_ROWS [NUM_DIR_ROWS] = '{
        // length still at its reset value of zero, so the byte is dropped
        '{1'b0, 16'd0,  8'hFF, 1'b1, 5'd0,  8'h00},
        // length 21, the last token straddles the end
        '{1'b1, 16'd21, 8'hF5, 1'b1, 5'd0,  8'h00},
        '{1'b0, 16'd0,  8'h00, 1'b1, 5'd1,  8'h00},
        // match far behind the start of output: eighteen zeros
        '{1'b0, 16'd0,  8'hFF, 1'b1, 5'd0,  8'h00},
        '{1'b0, 16'd0,  8'hFF, 1'b1, 5'd18, 8'h00},
        '{1'b0, 16'd0,  8'hFF, 1'b1, 5'd1,  8'hFF},
        // distance one: the last literal repeats eighteen times
        '{1'b0, 16'd0,  8'h01, 1'b1, 5'd0,  8'h00},
        '{1'b0, 16'd0,  8'h0F, 1'b1, 5'd18, 8'hFF},
        '{1'b0, 16'd0,  8'h5A, 1'b1, 5'd1,  8'h5A},
        '{1'b0, 16'd0,  8'hA5, 1'b1, 5'd1,  8'hA5},
        '{1'b0, 16'd0,  8'h3C, 1'b1, 5'd1,  8'h3C},
        '{1'b0, 16'd0,  8'hC3, 1'b1, 5'd1,  8'hC3},
        '{1'b0, 16'd0,  8'h00, 1'b1, 5'd0,  8'h00},
        // zero distance at write position 42: stale window bytes
        '{1'b0, 16'd0,  8'h18, 1'b0, 5'd0,  8'h00},
        '{1'b0, 16'd0,  8'h00, 1'b0, 5'd0,  8'h00},
        // plain back reference
        '{1'b0, 16'd0,  8'h00, 1'b0, 5'd0,  8'h00},
        '{1'b0, 16'd0,  8'h03, 1'b0, 5'd0,  8'h00},
        '{1'b0, 16'd0,  8'h10, 1'b0, 5'd0,  8'h00},
        '{1'b0, 16'd0,  8'h21, 1'b0, 5'd0,  8'h00},
        '{1'b0, 16'd0,  8'h30, 1'b0, 5'd0,  8'h00},
        '{1'b0, 16'd0,  8'hF4, 1'b0, 5'd0,  8'h00},
        // match starts as the 21st byte, its second byte lies past the end
        '{1'b0, 16'd0,  8'h7E, 1'b0, 5'd0,  8'h00},
        '{1'b0, 16'd0,  8'h81, 1'b0, 5'd0,  8'h00},
        // token starts past the end are dropped
        '{1'b0, 16'd0,  8'h99, 1'b1, 5'd0,  8'h00},
        '{1'b0, 16'd0,  8'h00, 1'b1, 5'd0,  8'h00}
    };

    // decoder state mirrored by the testbench
    logic [7:0]  win_mem [0:4095];
    logic [7:0]  desc_bits;
    logic [3:0]  desc_left;
    t_phase      parse_st;
    logic [7:0]  match_lo;
    logic [11:0] wr_ptr;
    logic [12:0] out_count;
    logic [15:0] in_count;
    logic [15:0] stream_len;

    t_out_item   decoded_q [$];
    t_out_item   pending_out_q [$];
    t_out_item   head_item;

    // stimulus shaping
    int          tx_idle_pct = 0;
    int          rx_idle_pct = 0;
    int          lit_pct     = 60;
    int          noise_pct   = 20;
    logic [3:0]  match_hi_pick = 4'h0;
    logic        hold_req = 1'b0;

    int          fail_count  = 0;
    int          out_checked = 0;
    int          items_sent  = 0;
    int          cycle_count = 0;

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // window write with wrap, produced count saturates at the window size
    function automatic void store_byte(input logic [7:0] v);
        win_mem[wr_ptr] = v;
        wr_ptr = wr_ptr + 12'd1;
        if (out_count < WIN_FULL)
            out_count = out_count + 13'd1;
    endfunction

    function automatic void end_token();
        desc_bits = desc_bits >> 1;
        if (desc_left != 4'd0)
            desc_left = desc_left - 4'd1;
        parse_st = PH_START;
    endfunction

    function automatic void emit_literal(input logic [7:0] b);
        store_byte(b);
        decoded_q.push_back('{data: b, last: 1'b1});
        end_token();
    endfunction

    // one compressed byte in, its decompressed bytes into decoded_q
    function automatic void decode_step(input logic [7:0] b);
        logic [11:0] addr;
        logic [11:0] back_dist;
        logic [11:0] rd_ptr;
        logic [7:0]  v;
        logic        zero_fill;
        int          len;
        int          k;
        decoded_q.delete();
        // byte arriving at a token start past the end changes nothing
        if (parse_st == PH_START && in_count >= stream_len)
            return;
        if (in_count != CNT_MAX)
            in_count = in_count + 16'd1;
        case (parse_st)
            PH_START: begin
                if (desc_left == 4'd0) begin
                    desc_bits = b;
                    desc_left = FLAGS_PER_DESC;
                    parse_st  = b[0] ? PH_LITERAL : PH_MATCH_LO;
                end else if (desc_bits[0]) begin
                    emit_literal(b);
                end else begin
                    match_lo = b;
                    parse_st = PH_MATCH_HI;
                end
            end
            PH_LITERAL: begin
                emit_literal(b);
            end
            PH_MATCH_LO: begin
                match_lo = b;
                parse_st = PH_MATCH_HI;
            end
            default: begin
                addr      = {b[7:4], match_lo} + ADDR_BIAS;
                len       = int'(b[3:0]) + int'(LEN_M1_BIAS) + 1;
                back_dist = wr_ptr - addr;
                // reference before the first byte ever produced reads as zeros
                zero_fill = ({1'b0, back_dist} > out_count);
                for (k = 0; k < len; k++) begin
                    rd_ptr = wr_ptr - back_dist;
                    v = zero_fill ? 8'h00 : win_mem[rd_ptr];
                    store_byte(v);
                    decoded_q.push_back('{data: v, last: (k == len - 1)});
                end
                end_token();
            end
        endcase
    endfunction

    // next byte of a well-formed stream, shaped by the current parse state
    function automatic logic [7:0] pick_byte();
        logic [7:0]  v;
        logic [11:0] back_dist;
        logic [11:0] field;
        int          k;
        if ($urandom_range(99) < noise_pct)
            return 8'($urandom);
        if (parse_st == PH_START && desc_left == 4'd0) begin
            for (k = 0; k < 8; k++)
                v[k] = ($urandom_range(99) < lit_pct);
            return v;
        end
        if (parse_st == PH_LITERAL || (parse_st == PH_START && desc_bits[0]))
            return 8'($urandom);
        if (parse_st == PH_MATCH_HI)
            return {match_hi_pick, 4'($urandom)};
        // first match byte: mostly short distances into recent output
        if ($urandom_range(9) == 0)
            back_dist = 12'($urandom);
        else
            back_dist = 12'($urandom_range(1, 48));
        field = wr_ptr - back_dist - ADDR_BIAS;
        match_hi_pick = field[11:8];
        return field[7:0];
    endfunction

    // register write with a setup phase and an access phase, pready is tied high
    task automatic write_reg(input logic [2:0] addr, input logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (addr == REG_STREAM_LENGTH)
            stream_len = data[15:0];
    endtask

    // stop offering and wait for every expected byte, then some slack
    task automatic drain(input int extra);
        i_valid <= 1'b0;
        while (pending_out_q.size() != 0)
            @(posedge i_clk);
        repeat (extra) @(posedge i_clk);
    endtask

    // offer one compressed byte and wait for its handshake
    task automatic send_item(input logic [7:0] b, input logic typed_en,
                             input logic [4:0] typed_n, input logic [7:0] typed_val);
        int k;
        while ($urandom_range(99) < tx_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        decode_step(b);
        if (typed_en) begin
            for (k = 0; k < int'(typed_n); k++)
                pending_out_q.push_back('{data: typed_val, last: (k == int'(typed_n) - 1)});
        end else begin
            foreach (decoded_q[k])
                pending_out_q.push_back(decoded_q[k]);
        end
        i_valid   <= 1'b1;
        i_in_byte <= b;
        @(posedge i_clk);
        while (!o_ready)
            @(posedge i_clk);
        items_sent++;
    endtask

    // receiver: random back pressure, or a long hold-off on request
    initial begin
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                hold_req = 1'b0;
                i_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end
            i_ready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    // output checker, oldest expectation first
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            out_checked++;
            if (pending_out_q.size() == 0) begin
                if (fail_count < MAX_REPORTS)
                    $error("out_byte %02h arrived with nothing expected", o_out_byte);
                fail_count++;
            end else begin
                head_item = pending_out_q.pop_front();
                if (o_out_byte !== head_item.data) begin
                    if (fail_count < MAX_REPORTS)
                        $error("out_byte mismatch: expected %02h, actual %02h",
                               head_item.data, o_out_byte);
                    fail_count++;
                end
                if (o_last_of_run !== head_item.last) begin
                    if (fail_count < MAX_REPORTS)
                        $error("last_of_run mismatch: expected %0b, actual %0b",
                               head_item.last, o_last_of_run);
                    fail_count++;
                end
            end
        end
    end

    // watchdog
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("TB_ERROR");
        $finish;
    end

    initial begin : stimulus
        int k;
        int p;
        // mirror of the reset state, history cleared
        for (k = 0; k < 4096; k++)
            win_mem[k] = 8'h00;
        desc_bits  = 8'h00;
        desc_left  = 4'd0;
        parse_st   = PH_START;
        match_lo   = 8'h00;
        wr_ptr     = 12'd0;
        out_count  = 13'd0;
        in_count   = 16'd0;
        stream_len = 16'd0;

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed table, first idling pattern
        tx_idle_pct = 16;
        rx_idle_pct = 61;
        for (k = 0; k < NUM_DIR_ROWS; k++) begin
            if (DIR_ROWS[k].cfg_en) begin
                drain(DRAIN_CYCLES);
                write_reg(REG_STREAM_LENGTH, {16'h0000, DIR_ROWS[k].cfg_len});
            end
            send_item(DIR_ROWS[k].data, DIR_ROWS[k].typed_en,
                      DIR_ROWS[k].typed_n, DIR_ROWS[k].typed_val);
        end

        // write to a hole in the map, then length zero with junk upper bits
        drain(DRAIN_CYCLES);
        write_reg(REG_UNMAPPED, $urandom);
        write_reg(REG_STREAM_LENGTH, 32'hFFFF_0000);
        repeat (3) send_item(pick_byte(), 1'b0, 5'd0, 8'd0);

        // random streams, each cut off partway so the tail is dropped
        for (p = 0; p < 3; p++) begin
            tx_idle_pct = (p == 0) ? 16 : (p == 1) ? 61 : 0;
            rx_idle_pct = (p == 0) ? 61 : (p == 1) ? 16 : 0;
            drain(DRAIN_CYCLES);
            write_reg(REG_STREAM_LENGTH, {16'($urandom), in_count + 16'd12});
            // long receiver hold-off while bytes keep coming
            if (p == 2)
                hold_req = 1'b1;
            for (k = 0; k < PHASE_ITEMS; k++) begin
                // sender waits out every pending byte once
                if (p == 0 && k == PHASE_ITEMS / 2)
                    drain(1);
                send_item(pick_byte(), 1'b0, 5'd0, 8'd0);
            end
        end

        // largest length: token starts are taken again, mostly literals
        drain(DRAIN_CYCLES);
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        lit_pct     = 95;
        noise_pct   = 0;
        write_reg(REG_STREAM_LENGTH, 32'h0000_FFFF);
        repeat (12) send_item(pick_byte(), 1'b0, 5'd0, 8'd0);

        drain(DRAIN_CYCLES);
        $display("sent %0d compressed bytes, checked %0d decompressed bytes in %0d cycles",
                 items_sent, out_checked, cycle_count);
        $display("literals, matches, zero fill, stale reads, straddle, drops, count %0d",
                 in_count);
        if (fail_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

@@ sim.f @@
+incdir+rtl
rtl/saxlz_pkg.sv
rtl/saxlz_front.sv
rtl/saxlz_fifo.sv
rtl/saxlz_back.sv
rtl/saxman_lzss_decompressor_unit.sv
test/tb_saxman_lzss_decompressor_unit.sv
